@@ rtl/core/pba_pkg.sv @@
// Package for the partition and buddy allocator: sizes, codes, table entry
// types and small helper functions. No dependencies.
package pba_pkg;

  // Sizes of the managed memory and of the tables.
  localparam int MEM_WORDS  = 1024;
  localparam int FREE_SLOTS = 64;
  localparam int MAX_ALLOCS = 32;

  // Field widths.
  localparam int ADDR_W   = 10;
  localparam int LEN_W    = 11;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;
  localparam int FUNC_W   = 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 11;

  // Derived widths: the free table RAM keeps one spare row for the transient
  // entry of a buddy split that is dropped again right after.
  localparam int FR_DEPTH = FREE_SLOTS + 1;
  localparam int FR_AW    = $clog2(FR_DEPTH);
  localparam int FC_W     = $clog2(FREE_SLOTS + 2);
  localparam int AS_W     = $clog2(MAX_ALLOCS);
  localparam int SPL_W    = $clog2(LEN_W + 1);
  localparam int MB_W     = $clog2(ADDR_W);

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADH  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd4;

  // Placement modes.
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BUDDY = 2'd3;

  // Item functions.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMSIZE = 1'b1;

  localparam logic [CFG_W-1:0] MEMSIZE_RESET = 11'd1024;

  // One free table row.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } fe_t;

  // One allocation table row.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ADDR_W-1:0]   start;
    logic [LEN_W-1:0]    len;
  } ae_t;

  // Largest power of two not above m (zero for zero).
  function automatic logic [LEN_W-1:0] floor_pow2(logic [LEN_W-1:0] m);
    logic [LEN_W-1:0] r;
    r = '0;
    for (int b = 0; b < LEN_W; b++) begin
      if (m[b]) r = LEN_W'(1) << b;
    end
    return r;
  endfunction

  // Smallest power of two not below x.
  function automatic logic [LEN_W:0] ceil_pow2(logic [LEN_W-1:0] x);
    logic [LEN_W:0] r;
    r = '0;
    for (int b = LEN_W; b >= 0; b--) begin
      if (((LEN_W+1)'(1) << b) >= (LEN_W+1)'(x)) r = (LEN_W+1)'(1) << b;
    end
    return r;
  endfunction

  // Lowest unused allocation slot; top bit says one was found.
  function automatic logic [AS_W:0] first_free(logic [MAX_ALLOCS-1:0] v);
    logic [AS_W:0] r;
    r = '0;
    for (int k = MAX_ALLOCS - 1; k >= 0; k--) begin
      if (!v[k]) r = {1'b1, AS_W'(k)};
    end
    return r;
  endfunction

endpackage

@@ rtl/core/pba_if.sv @@
// Valid/ready channel interfaces for the allocator's request and result items.
// Depends on pba_pkg for the field widths.
interface pba_cmd_if import pba_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [LEN_W-1:0]    request_size;
  logic [HANDLE_W-1:0] handle_in;

  modport source (output valid, func, request_size, handle_in, input ready);
  modport sink (input valid, func, request_size, handle_in, output ready);
endinterface

interface pba_rsp_if import pba_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] handle_out;
  logic [ADDR_W-1:0]   start_address;
  logic [LEN_W-1:0]    granted_size;

  modport source (output valid, status, handle_out, start_address, granted_size,
                  input ready);
  modport sink (input valid, status, handle_out, start_address, granted_size,
                output ready);
endinterface

@@ rtl/core/partition_and_buddy_allocator.sv @@
// Top level of the partition and buddy allocator.
// Depends on pba_pkg, the pba_cmd_if/pba_rsp_if interfaces and pba_ram.

// Each request item is handled alone; the block takes a new one when the
// previous result has been passed to the output register. The time per item
// is set by the free table RAM, with one write and one read port, visited
// one row at a time: an allocate scans free table rows and moves rows when a
// row is dropped or inserted (a buddy split inserts one row per halving); a
// free searches the allocation slots, scans free table rows, moves rows, and
// in buddy mode checks each merge, where a 10 step remainder unit tests
// alignment. The free table is laid out on the first item after reset; no
// clearing pass is needed.
module partition_and_buddy_allocator import pba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  pba_cmd_if.sink              cmd,
  pba_rsp_if.source            rsp
);

  typedef enum logic [23:0] {
    S_IDLE     = 24'h000001,
    S_INIT     = 24'h000002,
    S_DISP     = 24'h000004,
    S_ASC_RD   = 24'h000008,
    S_ASC_EV   = 24'h000010,
    S_ACHOSE   = 24'h000020,
    S_BCOUNT   = 24'h000040,
    S_BSPLIT   = 24'h000080,
    S_CARVE    = 24'h000100,
    S_AFIN     = 24'h000200,
    S_HSC_RD   = 24'h000400,
    S_HSC_EV   = 24'h000800,
    S_FSC_RD   = 24'h001000,
    S_FSC_EV   = 24'h002000,
    S_FDEC     = 24'h004000,
    S_MPREV    = 24'h008000,
    S_MPREV_EV = 24'h010000,
    S_MNEXT    = 24'h020000,
    S_MNEXT_EV = 24'h040000,
    S_MOD      = 24'h080000,
    S_FFIN     = 24'h100000,
    S_SW_RD    = 24'h200000,
    S_SW_WR    = 24'h400000,
    S_DONE     = 24'h800000
  } state_t;

  state_t state, ret_state;

  // Configuration registers.
  logic [MODE_W-1:0] alloc_mode;
  logic [CFG_W-1:0]  managed_words;

  // Allocator state.
  logic                  initialized;
  logic [FC_W-1:0]       fc;
  logic [MAX_ALLOCS-1:0] valid;
  logic [HANDLE_W-1:0]   next_handle;

  // Current item.
  logic [FUNC_W-1:0]   op_func;
  logic [LEN_W-1:0]    op_req;
  logic [HANDLE_W-1:0] op_hin;

  // Working registers.
  logic [LEN_W:0]      areq;
  logic                found;
  logic [FC_W-1:0]     c_idx;
  logic [ADDR_W-1:0]   cs;
  logic [LEN_W-1:0]    cl;
  logic [LEN_W-1:0]    t_len;
  logic [SPL_W-1:0]    splits;
  logic [AS_W-1:0]     slot;
  logic [FC_W-1:0]     fj;
  logic [AS_W:0]       aj;
  logic [ADDR_W-1:0]   s_st;
  logic [LEN_W-1:0]    s_len;
  fe_t                 prev_e, cur_e;
  logic [FC_W-1:0]     ci;
  logic                sw_up;
  logic [FC_W-1:0]     sw_k, sw_i;
  fe_t                 ins_e;
  logic [ADDR_W-1:0]   mod_a;
  logic [LEN_W:0]      mod_d;
  logic [LEN_W:0]      mod_r;
  logic [MB_W-1:0]     mod_n;
  logic                mod_next;

  // Result staging and output register.
  logic [STATUS_W-1:0] res_status;
  logic [HANDLE_W-1:0] res_h;
  logic [ADDR_W-1:0]   res_st;
  logic [LEN_W-1:0]    res_gs;
  logic                o_valid;
  logic [STATUS_W-1:0] o_status;
  logic [HANDLE_W-1:0] o_h;
  logic [ADDR_W-1:0]   o_st;
  logic [LEN_W-1:0]    o_gs;

  // RAM ports.
  logic             fr_we;
  logic [FR_AW-1:0] fr_waddr, fr_raddr;
  fe_t              fr_wdata, fr_rdata;
  logic             ar_we;
  logic [AS_W-1:0]  ar_raddr;
  ae_t              ar_wdata, ar_rdata;

  // Derived values.
  logic             buddy;
  logic [LEN_W-1:0] m_clamp, init_len;
  logic [AS_W:0]    ff;
  logic [FC_W-1:0]  ci_m1, ci_p1, sw_km1, sw_kp1;
  logic [LEN_W:0]   cl2;
  logic [LEN_W-1:0] half;
  logic             fit;
  logic             mp, mn;
  logic [FC_W:0]    bneed;
  logic [LEN_W+1:0] mod_r2;
  logic [LEN_W:0]   mod_rn;
  logic             mod_zero;
  logic             carve_drop;
  logic             p_match, n_match;

  assign buddy   = (alloc_mode == MODE_BUDDY);
  assign m_clamp = (managed_words > LEN_W'(MEM_WORDS)) ? LEN_W'(MEM_WORDS) : managed_words;
  assign init_len = buddy ? floor_pow2(m_clamp) : m_clamp;
  assign ff      = first_free(valid);
  assign ci_m1   = ci - 1'b1;
  assign ci_p1   = ci + 1'b1;
  assign sw_km1  = sw_k - 1'b1;
  assign sw_kp1  = sw_k + 1'b1;
  assign cl2     = {cl, 1'b0};
  assign half    = cl >> 1;
  assign fit     = ((LEN_W+1)'(fr_rdata.len) >= areq);
  assign carve_drop = ((LEN_W+1)'(cl) == areq);

  // Neighbor tests for a non-buddy free.
  assign mp = (ci != '0) &&
              ((LEN_W+1)'(prev_e.start) + (LEN_W+1)'(prev_e.len) == (LEN_W+1)'(s_st));
  assign mn = (ci < fc) &&
              ((LEN_W+1)'(s_st) + (LEN_W+1)'(s_len) == (LEN_W+1)'(cur_e.start));

  // Buddy candidates: same length and touching; alignment is checked after.
  assign p_match = (fr_rdata.len == cl) &&
                   ((LEN_W+1)'(fr_rdata.start) + (LEN_W+1)'(cl) == (LEN_W+1)'(cs));
  assign n_match = (fr_rdata.len == cl) &&
                   ((LEN_W+1)'(cs) + (LEN_W+1)'(cl) == (LEN_W+1)'(fr_rdata.start));

  // Free table rows needed after all buddy splits of the chosen block.
  assign bneed = (FC_W+1)'(fc) + (FC_W+1)'(splits) -
                 (((LEN_W+1)'(t_len) == areq) ? (FC_W+1)'(1) : (FC_W+1)'(0));

  // One restoring remainder step per cycle.
  assign mod_r2   = {mod_r, mod_a[mod_n]};
  assign mod_rn   = (mod_r2 >= (LEN_W+2)'(mod_d)) ? (LEN_W+1)'(mod_r2 - (LEN_W+2)'(mod_d))
                                                   : (LEN_W+1)'(mod_r2);
  assign mod_zero = (mod_rn == '0);

  pba_ram #(.WIDTH($bits(fe_t)), .DEPTH(FR_DEPTH)) u_free_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  pba_ram #(.WIDTH($bits(ae_t)), .DEPTH(MAX_ALLOCS)) u_alloc_ram (
    .clk   (clk),
    .we    (ar_we),
    .waddr (slot),
    .wdata (ar_wdata),
    .raddr (ar_raddr),
    .rdata (ar_rdata)
  );

  // Free table RAM control, decided by the sequencer state.
  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = '0;
    fr_wdata = '0;
    fr_raddr = '0;
    case (state)
      S_INIT: begin
        fr_we    = (m_clamp != '0);
        fr_wdata = '{start: '0, len: init_len};
      end
      S_ASC_RD, S_FSC_RD: begin
        fr_raddr = fj[FR_AW-1:0];
      end
      S_MPREV: begin
        fr_raddr = ci_m1[FR_AW-1:0];
      end
      S_MNEXT: begin
        fr_raddr = ci_p1[FR_AW-1:0];
      end
      S_SW_RD: begin
        if (sw_up) begin
          if (sw_k > sw_i) begin
            fr_raddr = sw_km1[FR_AW-1:0];
          end else begin
            fr_we    = 1'b1;
            fr_waddr = sw_i[FR_AW-1:0];
            fr_wdata = ins_e;
          end
        end else begin
          fr_raddr = sw_kp1[FR_AW-1:0];
        end
      end
      S_SW_WR: begin
        fr_we    = 1'b1;
        fr_waddr = sw_k[FR_AW-1:0];
        fr_wdata = fr_rdata;
      end
      S_CARVE: begin
        if (!carve_drop) begin
          fr_we    = 1'b1;
          fr_waddr = c_idx[FR_AW-1:0];
          fr_wdata = '{start: cs + ADDR_W'(areq), len: cl - LEN_W'(areq)};
        end
      end
      S_FDEC: begin
        if (!buddy) begin
          if (mp) begin
            fr_we    = 1'b1;
            fr_waddr = ci_m1[FR_AW-1:0];
            fr_wdata = '{start: prev_e.start,
                         len: prev_e.len + s_len + (mn ? cur_e.len : LEN_W'(0))};
          end else if (mn) begin
            fr_we    = 1'b1;
            fr_waddr = ci[FR_AW-1:0];
            fr_wdata = '{start: s_st, len: cur_e.len + s_len};
          end
        end
      end
      S_MOD: begin
        if (mod_n == '0 && mod_zero) begin
          fr_we = 1'b1;
          if (mod_next) begin
            fr_waddr = ci[FR_AW-1:0];
            fr_wdata = '{start: cs, len: LEN_W'(cl2)};
          end else begin
            fr_waddr = ci_m1[FR_AW-1:0];
            fr_wdata = '{start: prev_e.start, len: LEN_W'(cl2)};
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Allocation table RAM control.
  assign ar_we    = (state == S_AFIN);
  assign ar_wdata = '{handle: next_handle, start: res_st, len: res_gs};
  assign ar_raddr = aj[AS_W-1:0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_mode    <= MODE_BEST;
      managed_words <= MEMSIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:    alloc_mode    <= cfg_data[MODE_W-1:0];
        CFG_MEMSIZE: managed_words <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ret_state   <= S_IDLE;
      initialized <= 1'b0;
      fc          <= '0;
      valid       <= '0;
      next_handle <= '0;
      o_valid     <= 1'b0;
    end else begin
      // The result register empties when taken, unless a new result loads it.
      if (o_valid && rsp.ready && state != S_DONE) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op_func <= cmd.func;
            op_req  <= cmd.request_size;
            op_hin  <= cmd.handle_in;
            state   <= initialized ? S_DISP : S_INIT;
          end
        end
        S_INIT: begin
          fc          <= (m_clamp != '0) ? FC_W'(1) : FC_W'(0);
          initialized <= 1'b1;
          state       <= S_DISP;
        end
        S_DISP: begin
          fj    <= '0;
          aj    <= '0;
          found <= 1'b0;
          if (op_func == FUNC_FREE) begin
            state <= S_HSC_RD;
          end else if (op_req == '0) begin
            res_status <= ST_ZERO;
            res_h <= '0; res_st <= '0; res_gs <= '0;
            state <= S_DONE;
          end else if (!ff[AS_W]) begin
            res_status <= ST_FULL;
            res_h <= '0; res_st <= '0; res_gs <= '0;
            state <= S_DONE;
          end else begin
            slot  <= ff[AS_W-1:0];
            areq  <= buddy ? ceil_pow2(op_req) : (LEN_W+1)'(op_req);
            state <= S_ASC_RD;
          end
        end
        // Scan the free table for a block that fits.
        S_ASC_RD: begin
          state <= (fj < fc) ? S_ASC_EV : S_ACHOSE;
        end
        S_ASC_EV: begin
          fj    <= fj + 1'b1;
          state <= S_ASC_RD;
          if (fit && !found) begin
            found <= 1'b1;
            c_idx <= fj;
            cs    <= fr_rdata.start;
            cl    <= fr_rdata.len;
            if (buddy || alloc_mode == MODE_FIRST) state <= S_ACHOSE;
          end else if (fit && ((alloc_mode == MODE_BEST && fr_rdata.len < cl) ||
                               (alloc_mode == MODE_WORST && fr_rdata.len > cl))) begin
            c_idx <= fj;
            cs    <= fr_rdata.start;
            cl    <= fr_rdata.len;
          end
        end
        S_ACHOSE: begin
          t_len  <= cl;
          splits <= '0;
          if (!found) begin
            res_status <= ST_NOFIT;
            res_h <= '0; res_st <= '0; res_gs <= '0;
            state <= S_DONE;
          end else begin
            state <= buddy ? S_BCOUNT : S_CARVE;
          end
        end
        // Count the halvings, then check the free table has room.
        S_BCOUNT: begin
          if ((LEN_W+1)'(t_len >> 1) >= areq) begin
            t_len  <= t_len >> 1;
            splits <= splits + 1'b1;
          end else if (bneed > (FC_W+1)'(FREE_SLOTS)) begin
            res_status <= ST_FULL;
            res_h <= '0; res_st <= '0; res_gs <= '0;
            state <= S_DONE;
          end else begin
            state <= S_BSPLIT;
          end
        end
        // Halve the chosen block; the upper half is inserted after it.
        S_BSPLIT: begin
          if ((LEN_W+1)'(half) >= areq) begin
            ins_e     <= '{start: cs + ADDR_W'(half), len: cl - half};
            sw_up     <= 1'b1;
            sw_i      <= c_idx + 1'b1;
            sw_k      <= fc;
            ret_state <= S_BSPLIT;
            cl        <= half;
            state     <= S_SW_RD;
          end else begin
            state <= S_CARVE;
          end
        end
        S_CARVE: begin
          res_st <= cs;
          res_gs <= LEN_W'(areq);
          if (carve_drop) begin
            sw_up     <= 1'b0;
            sw_k      <= c_idx;
            ret_state <= S_AFIN;
            state     <= S_SW_RD;
          end else begin
            state <= S_AFIN;
          end
        end
        S_AFIN: begin
          valid[slot] <= 1'b1;
          res_status  <= ST_OK;
          res_h       <= next_handle;
          next_handle <= next_handle + 1'b1;
          state       <= S_DONE;
        end
        // Look up the handle in the allocation table.
        S_HSC_RD: begin
          if (aj < (AS_W+1)'(MAX_ALLOCS)) begin
            state <= S_HSC_EV;
          end else begin
            res_status <= ST_BADH;
            res_h <= '0; res_st <= '0; res_gs <= '0;
            state <= S_DONE;
          end
        end
        S_HSC_EV: begin
          if (valid[aj[AS_W-1:0]] && ar_rdata.handle == op_hin) begin
            slot  <= aj[AS_W-1:0];
            s_st  <= ar_rdata.start;
            s_len <= ar_rdata.len;
            fj    <= '0;
            state <= S_FSC_RD;
          end else begin
            aj    <= aj + 1'b1;
            state <= S_HSC_RD;
          end
        end
        // Find the first free row at or above the released block.
        S_FSC_RD: begin
          if (fj < fc) begin
            state <= S_FSC_EV;
          end else begin
            ci    <= fc;
            state <= S_FDEC;
          end
        end
        S_FSC_EV: begin
          if (fr_rdata.start < s_st) begin
            prev_e <= fr_rdata;
            fj     <= fj + 1'b1;
            state  <= S_FSC_RD;
          end else begin
            cur_e <= fr_rdata;
            ci    <= fj;
            state <= S_FDEC;
          end
        end
        S_FDEC: begin
          if (buddy || !(mp || mn)) begin
            if (fc >= FC_W'(FREE_SLOTS)) begin
              res_status <= ST_FULL;
              res_h <= '0; res_st <= '0; res_gs <= '0;
              state <= S_DONE;
            end else begin
              ins_e     <= '{start: s_st, len: s_len};
              sw_up     <= 1'b1;
              sw_i      <= ci;
              sw_k      <= fc;
              ret_state <= buddy ? S_MPREV : S_FFIN;
              cs        <= s_st;
              cl        <= s_len;
              state     <= S_SW_RD;
            end
          end else if (mp && mn) begin
            sw_up     <= 1'b0;
            sw_k      <= ci;
            ret_state <= S_FFIN;
            state     <= S_SW_RD;
          end else begin
            state <= S_FFIN;
          end
        end
        // Buddy merging: try the lower neighbor, then the upper one.
        S_MPREV: begin
          state <= (ci != '0) ? S_MPREV_EV : S_MNEXT;
        end
        S_MPREV_EV: begin
          if (p_match) begin
            prev_e   <= fr_rdata;
            mod_a    <= fr_rdata.start;
            mod_d    <= cl2;
            mod_r    <= '0;
            mod_n    <= MB_W'(ADDR_W - 1);
            mod_next <= 1'b0;
            state    <= S_MOD;
          end else begin
            state <= S_MNEXT;
          end
        end
        S_MNEXT: begin
          state <= (ci_p1 < fc) ? S_MNEXT_EV : S_FFIN;
        end
        S_MNEXT_EV: begin
          if (n_match) begin
            mod_a    <= cs;
            mod_d    <= cl2;
            mod_r    <= '0;
            mod_n    <= MB_W'(ADDR_W - 1);
            mod_next <= 1'b1;
            state    <= S_MOD;
          end else begin
            state <= S_FFIN;
          end
        end
        // Alignment check of the lower buddy's start, then the merge.
        S_MOD: begin
          mod_r <= mod_rn;
          if (mod_n != '0) begin
            mod_n <= mod_n - 1'b1;
          end else if (mod_zero) begin
            sw_up     <= 1'b0;
            ret_state <= S_MPREV;
            cl        <= LEN_W'(cl2);
            state     <= S_SW_RD;
            if (mod_next) begin
              sw_k <= ci_p1;
            end else begin
              sw_k <= ci;
              ci   <= ci_m1;
              cs   <= prev_e.start;
            end
          end else begin
            state <= mod_next ? S_FFIN : S_MNEXT;
          end
        end
        S_FFIN: begin
          valid[slot] <= 1'b0;
          res_status  <= ST_OK;
          res_h       <= op_hin;
          res_st      <= s_st;
          res_gs      <= s_len;
          state       <= S_DONE;
        end
        // Row move for insert (upward) or drop (downward), one row per pass.
        S_SW_RD: begin
          if (sw_up) begin
            if (sw_k > sw_i) begin
              state <= S_SW_WR;
            end else begin
              fc    <= fc + 1'b1;
              state <= ret_state;
            end
          end else begin
            if (sw_kp1 < fc) begin
              state <= S_SW_WR;
            end else begin
              fc    <= fc - 1'b1;
              state <= ret_state;
            end
          end
        end
        S_SW_WR: begin
          sw_k  <= sw_up ? sw_km1 : sw_kp1;
          state <= S_SW_RD;
        end
        S_DONE: begin
          if (!o_valid || rsp.ready) begin
            o_valid  <= 1'b1;
            o_status <= res_status;
            o_h      <= res_h;
            o_st     <= res_st;
            o_gs     <= res_gs;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd.ready         = (state == S_IDLE);
  assign rsp.valid         = o_valid;
  assign rsp.status        = o_status;
  assign rsp.handle_out    = o_h;
  assign rsp.start_address = o_st;
  assign rsp.granted_size  = o_gs;

  // An accepted item keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("request accepted while the previous item was still in work");

  // The free table never holds more rows than its slots between items.
  a_fc_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> fc <= FC_W'(FREE_SLOTS))
    else $error("free table row count above its slot count");

  // An error result carries zero fields.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |->
      rsp.handle_out == '0 && rsp.start_address == '0 && rsp.granted_size == '0)
    else $error("error result with nonzero fields");

endmodule

@@ rtl/core/pba_ram.sv @@
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
